FILE: sv/ata_pkg.sv
`default_nettype none
package ata_pkg;

    localparam int ROTATION_STEPS = 16;
    localparam int STEP_TABLE_SIZE = 24;
    localparam int CORDIC_STEPS =
        (ROTATION_STEPS < STEP_TABLE_SIZE) ? ROTATION_STEPS : STEP_TABLE_SIZE;

    localparam int OP_W = 28;
    localparam int ANG_W = 26;
    localparam int ROOT_W = 24;
    localparam int RAD_W = 2 * ROOT_W;
    localparam int SQRT_STAGES = ROOT_W;

    typedef logic signed [OP_W-1:0] op_t;
    typedef logic signed [ANG_W-1:0] ang_t;

    localparam ang_t DEG90_FINE = ANG_W'(90 * 65536);
    localparam ang_t DEG180_FINE = ANG_W'(180 * 65536);
    localparam logic signed [18:0] ROLL_LIMIT = 19'sd46080;
    localparam logic signed [18:0] PITCH_LIMIT = 19'sd23040;

    function automatic ang_t atan_fine(input logic [4:0] idx);
        ang_t r;
        case (idx)
            5'd0: r = ANG_W'(2949120);
            5'd1: r = ANG_W'(1740967);
            5'd2: r = ANG_W'(919879);
            5'd3: r = ANG_W'(466945);
            5'd4: r = ANG_W'(234379);
            5'd5: r = ANG_W'(117304);
            5'd6: r = ANG_W'(58666);
            5'd7: r = ANG_W'(29335);
            5'd8: r = ANG_W'(14668);
            5'd9: r = ANG_W'(7334);
            5'd10: r = ANG_W'(3667);
            5'd11: r = ANG_W'(1833);
            5'd12: r = ANG_W'(917);
            5'd13: r = ANG_W'(458);
            5'd14: r = ANG_W'(229);
            5'd15: r = ANG_W'(115);
            5'd16: r = ANG_W'(57);
            5'd17: r = ANG_W'(29);
            5'd18: r = ANG_W'(14);
            5'd19: r = ANG_W'(7);
            5'd20: r = ANG_W'(4);
            5'd21: r = ANG_W'(2);
            5'd22: r = ANG_W'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/ata_if.sv
`default_nettype none
interface ata_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface ata_out_if;
    logic valid;
    logic ready;
    logic signed [16:0] roll_angle;
    logic signed [15:0] pitch_angle;
    modport source (output valid, roll_angle, pitch_angle, input ready);
    modport sink (input valid, roll_angle, pitch_angle, output ready);
endinterface
`default_nettype wire

FILE: sv/accel_tilt_angles.sv
// channel   dir  payload
// sample    in   accel_x, accel_y, accel_z
// angles    out  roll_angle, pitch_angle
//
// One request enters per cycle while angles is not stalled.
// The pipeline runs through the 24-stage square root followed by the CORDIC stages.
// Reset clears the valid bits only.
// A stall at angles freezes the whole pipeline; sample ready follows it.
`default_nettype none
module accel_tilt_angles (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ata_in_if.sink     sample,
    ata_out_if.source  angles
);
    import ata_pkg::*;

    localparam int DLY = SQRT_STAGES;
    localparam int VLD = 28 + CORDIC_STEPS;

    logic en;
    logic [VLD-1:0] vld_reg;
    logic out_vld_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic signed [15:0] ay1_reg, az1_reg;
    logic signed [16:0] nx1_reg;
    logic [31:0] ysq_reg, zsq_reg;
    logic [31:0] sum_reg;
    logic signed [15:0] ay2_reg, az2_reg;
    logic signed [16:0] nx2_reg;
    logic signed [15:0] ayd_reg [DLY];
    logic signed [15:0] azd_reg [DLY];
    logic signed [16:0] nxd_reg [DLY];
    logic [ROOT_W-1:0] mag;
    ang_t roll_fine, pitch_fine;
    logic signed [ANG_W:0] roll_sum, pitch_sum;
    logic signed [18:0] roll_rnd, pitch_rnd;
    logic signed [16:0] roll_out_reg;
    logic signed [15:0] pitch_out_reg;

    assign en = !out_vld_reg || angles.ready;
    assign sample.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[VLD-2:0], sample.valid};
            out_vld_reg <= vld_reg[VLD-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg  <= sample.accel_x;
            ay_reg  <= sample.accel_y;
            az_reg  <= sample.accel_z;
            ysq_reg <= 32'(ay_reg * ay_reg);
            zsq_reg <= 32'(az_reg * az_reg);
            ay1_reg <= ay_reg;
            az1_reg <= az_reg;
            nx1_reg <= -17'(ax_reg);
            sum_reg <= ysq_reg + zsq_reg;
            ay2_reg <= ay1_reg;
            az2_reg <= az1_reg;
            nx2_reg <= nx1_reg;
            ayd_reg[0] <= ay2_reg;
            azd_reg[0] <= az2_reg;
            nxd_reg[0] <= nx2_reg;
            for (int j = 1; j < DLY; j++)
            begin
                ayd_reg[j] <= ayd_reg[j-1];
                azd_reg[j] <= azd_reg[j-1];
                nxd_reg[j] <= nxd_reg[j-1];
            end
        end
    end

    ata_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand ({sum_reg[RAD_W-17:0], 16'h0000}),
        .root     (mag)
    );

    ata_cordic u_roll (
        .clk   (clk),
        .en    (en),
        .num   (op_t'({{(OP_W-24){ayd_reg[DLY-1][15]}}, ayd_reg[DLY-1], 8'h00})),
        .den   (op_t'({{(OP_W-24){azd_reg[DLY-1][15]}}, azd_reg[DLY-1], 8'h00})),
        .angle (roll_fine)
    );

    ata_cordic u_pitch (
        .clk   (clk),
        .en    (en),
        .num   (op_t'({{(OP_W-25){nxd_reg[DLY-1][16]}}, nxd_reg[DLY-1], 8'h00})),
        .den   (op_t'({{(OP_W-ROOT_W){1'b0}}, mag})),
        .angle (pitch_fine)
    );

    assign roll_sum  = (ANG_W+1)'(roll_fine) + (ANG_W+1)'(128);
    assign pitch_sum = (ANG_W+1)'(pitch_fine) + (ANG_W+1)'(128);
    assign roll_rnd  = 19'(roll_sum >>> 8);
    assign pitch_rnd = 19'(pitch_sum >>> 8);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (roll_rnd > ROLL_LIMIT)
                roll_out_reg <= 17'(ROLL_LIMIT);
            else if (roll_rnd < -ROLL_LIMIT)
                roll_out_reg <= 17'(-ROLL_LIMIT);
            else
                roll_out_reg <= 17'(roll_rnd);
            if (pitch_rnd > PITCH_LIMIT)
                pitch_out_reg <= 16'(PITCH_LIMIT);
            else if (pitch_rnd < -PITCH_LIMIT)
                pitch_out_reg <= 16'(-PITCH_LIMIT);
            else
                pitch_out_reg <= 16'(pitch_rnd);
        end
    end

    assign angles.valid       = out_vld_reg;
    assign angles.roll_angle  = roll_out_reg;
    assign angles.pitch_angle = pitch_out_reg;
endmodule
`default_nettype wire

FILE: sv/ata_sqrt.sv
`default_nettype none
module ata_sqrt (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [ata_pkg::RAD_W-1:0]   radicand,
    output logic [ata_pkg::ROOT_W-1:0]       root
);
    import ata_pkg::*;

    logic [ROOT_W-1:0] root_reg [SQRT_STAGES];
    logic [ROOT_W:0]   rem_reg  [SQRT_STAGES];
    logic [RAD_W-1:0]  rest_reg [SQRT_STAGES];

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
            logic [ROOT_W-1:0] root_in;
            logic [ROOT_W:0]   rem_in;
            logic [RAD_W-1:0]  rest_in;
            logic [ROOT_W+2:0] rem2;
            logic [ROOT_W+2:0] trial;
            if (k == 0) begin : g_first
                assign root_in = '0;
                assign rem_in  = '0;
                assign rest_in = radicand;
            end else begin : g_next
                assign root_in = root_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign rest_in = rest_reg[k-1];
            end
            assign rem2  = {rem_in, rest_in[RAD_W-1 -: 2]};
            assign trial = {1'b0, root_in, 2'b01};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rest_reg[k] <= {rest_in[RAD_W-3:0], 2'b00};
                    if (rem2 >= trial)
                    begin
                        rem_reg[k]  <= (ROOT_W+1)'(rem2 - trial);
                        root_reg[k] <= {root_in[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k]  <= rem2[ROOT_W:0];
                        root_reg[k] <= {root_in[ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[SQRT_STAGES-1];
endmodule
`default_nettype wire

FILE: sv/ata_cordic.sv
`default_nettype none
module ata_cordic (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire ata_pkg::op_t   num,
    input  wire ata_pkg::op_t   den,
    output ata_pkg::ang_t       angle
);
    import ata_pkg::*;

    op_t  x_reg   [CORDIC_STEPS+1];
    op_t  y_reg   [CORDIC_STEPS+1];
    ang_t ang_reg [CORDIC_STEPS+1];
    logic sp_reg  [CORDIC_STEPS+1];
    ang_t spa_reg [CORDIC_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_reg[0] <= (num == '0) || (den == '0);
            if (num == '0)
                spa_reg[0] <= den[OP_W-1] ? DEG180_FINE : '0;
            else
                spa_reg[0] <= num[OP_W-1] ? -DEG90_FINE : DEG90_FINE;
            if (den[OP_W-1] && !num[OP_W-1])
            begin
                x_reg[0]   <= num;
                y_reg[0]   <= -den;
                ang_reg[0] <= DEG90_FINE;
            end
            else if (den[OP_W-1])
            begin
                x_reg[0]   <= -num;
                y_reg[0]   <= den;
                ang_reg[0] <= -DEG90_FINE;
            end
            else
            begin
                x_reg[0]   <= den;
                y_reg[0]   <= num;
                ang_reg[0] <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
            op_t xs;
            op_t ys;
            assign xs = x_reg[i] >>> i;
            assign ys = y_reg[i] >>> i;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sp_reg[i+1]  <= sp_reg[i];
                    spa_reg[i+1] <= spa_reg[i];
                    if (!y_reg[i][OP_W-1])
                    begin
                        x_reg[i+1]   <= x_reg[i] + ys;
                        y_reg[i+1]   <= y_reg[i] - xs;
                        ang_reg[i+1] <= ang_reg[i] + atan_fine(5'(i));
                    end
                    else
                    begin
                        x_reg[i+1]   <= x_reg[i] - ys;
                        y_reg[i+1]   <= y_reg[i] + xs;
                        ang_reg[i+1] <= ang_reg[i] - atan_fine(5'(i));
                    end
                end
            end
        end
    endgenerate

    assign angle = sp_reg[CORDIC_STEPS] ? spa_reg[CORDIC_STEPS] : ang_reg[CORDIC_STEPS];
endmodule
`default_nettype wire
